FILE: sv/quaternion_frame_rotation_top_macros.svh
`ifndef QUATERNION_FRAME_ROTATION_TOP_MACROS_SVH
`define QUATERNION_FRAME_ROTATION_TOP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define QFR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define QFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/qfr_pkg.sv
package qfr_pkg;

	localparam int COMP_W    = 16;
	localparam int FRAC_W    = 14;
	localparam int ROW_W     = 48;
	localparam int NUM_ROWS  = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW2 = 2'd2;

	localparam logic [ROW_W-1:0] MOUNT_RST0 = 48'd16384;
	localparam logic [ROW_W-1:0] MOUNT_RST1 = 48'd1073741824;
	localparam logic [ROW_W-1:0] MOUNT_RST2 = 48'd70368744177664;

	localparam int DVS_W   = 33;
	localparam int DVD_W   = DVS_W + FRAC_W;
	localparam int QB      = FRAC_W + 1;
	localparam int DIV_LAT = QB + 2;

	localparam int MAG_W   = 30;
	localparam int RAD_W   = 2 * MAG_W + 2;
	localparam int ROOT_W  = MAG_W + 1;
	localparam int SQ_LAT  = ROOT_W + 1;

	typedef struct packed {
		logic [3:0][MAG_W-1:0] mag;
		logic [3:0]            neg;
		logic                  deg;
		logic                  err;
	} qfr_side_t;

endpackage

FILE: sv/qfr_div.sv
module qfr_div (
	input  logic                              clk,
	input  logic                              en,
	input  logic [qfr_pkg::DVD_W-1:0]         dvd,
	input  logic [qfr_pkg::DVS_W-1:0]         dvs,
	input  logic                              neg,
	output logic signed [qfr_pkg::COMP_W-1:0] quo
);
	import qfr_pkg::*;

	logic [DVD_W-1:0] rem_s [0:QB-1];
	logic [DVS_W-1:0] dvs_s [0:QB-1];
	logic [QB-1:0]    quo_s [0:QB];
	logic             neg_s [0:QB];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= dvd;
			dvs_s[0] <= dvs;
			quo_s[0] <= '0;
			neg_s[0] <= neg;
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_step
		localparam int SH = QB - 1 - j;
		logic [DVD_W-1:0] trial;
		logic             take;

		assign trial = DVD_W'(dvs_s[j]) << SH;
		assign take  = rem_s[j] >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[j+1] <= {quo_s[j][QB-2:0], take};
				neg_s[j+1] <= neg_s[j];
			end
		end

		if (j < QB - 1) begin : g_fwd
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j+1] <= take ? rem_s[j] - trial : rem_s[j];
					dvs_s[j+1] <= dvs_s[j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= neg_s[QB] ? -signed'({1'b0, quo_s[QB]}) : signed'({1'b0, quo_s[QB]});
		end
	end

endmodule

FILE: sv/qfr_sqrt.sv
module qfr_sqrt (
	input  logic                       clk,
	input  logic                       en,
	input  logic [qfr_pkg::RAD_W-1:0]  rad,
	input  qfr_pkg::qfr_side_t         side_in,
	output logic [qfr_pkg::ROOT_W-1:0] root,
	output qfr_pkg::qfr_side_t         side_out
);
	import qfr_pkg::*;

	logic [RAD_W-1:0]  rem_s  [0:ROOT_W-1];
	logic [ROOT_W-1:0] root_s [0:ROOT_W];
	qfr_side_t         side_s [0:ROOT_W];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= rad;
			root_s[0] <= '0;
			side_s[0] <= side_in;
		end
	end

	for (genvar j = 0; j < ROOT_W; j++) begin : g_step
		localparam int BI = ROOT_W - 1 - j;
		logic [RAD_W-1:0] trial;
		logic             take;

		assign trial = (RAD_W'(root_s[j]) << (BI + 1)) | (RAD_W'(1) << (2 * BI));
		assign take  = rem_s[j] >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[j+1] <= take ? (root_s[j] | (ROOT_W'(1) << BI)) : root_s[j];
				side_s[j+1] <= side_s[j];
			end
		end

		if (j < ROOT_W - 1) begin : g_fwd
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j+1] <= take ? rem_s[j] - trial : rem_s[j];
				end
			end
		end
	end

	assign root     = root_s[ROOT_W];
	assign side_out = side_s[ROOT_W];

endmodule

FILE: sv/quaternion_frame_rotation_top.sv
// Throughput: one item per cycle; the pipeline halts only while the two-entry output
// queue is full.
// The depth is set by the two bit-per-stage dividers and the bit-per-stage square root.
// Reset clears all valid bits and the output queue and loads the identity mounting matrix.
`include "quaternion_frame_rotation_top_macros.svh"

module quaternion_frame_rotation_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [qfr_pkg::COMP_W-1:0]    in_w,
	input  logic signed [qfr_pkg::COMP_W-1:0]    in_x,
	input  logic signed [qfr_pkg::COMP_W-1:0]    in_y,
	input  logic signed [qfr_pkg::COMP_W-1:0]    in_z,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [qfr_pkg::COMP_W-1:0]    out_w,
	output logic signed [qfr_pkg::COMP_W-1:0]    out_x,
	output logic signed [qfr_pkg::COMP_W-1:0]    out_y,
	output logic signed [qfr_pkg::COMP_W-1:0]    out_z,
	output logic                                 status,
	input  logic                                 cfg_we,
	input  logic [qfr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [qfr_pkg::ROW_W-1:0]            cfg_wdata
);
	import qfr_pkg::*;

	localparam int PR_W     = 2 * COMP_W;
	localparam int NUM_W    = DVS_W + 1;
	localparam int PM_W     = 17;
	localparam int P_W      = PM_W + 1;
	localparam int C_W      = 20;
	localparam int CM_W     = 20;
	localparam int SH_W     = 5;
	localparam int SQM_W    = 2 * MAG_W;
	localparam int NORM_MSB = MAG_W - 1;
	localparam int FIFO_DEPTH = 2;
	localparam logic [PR_W-1:0] HALF_LSB = PR_W'(1) << (FRAC_W - 1);
	localparam logic signed [C_W-1:0] ONE_C = C_W'(1) << FRAC_W;

	typedef struct packed {
		logic [COMP_W-1:0] w;
		logic [COMP_W-1:0] x;
		logic [COMP_W-1:0] y;
		logic [COMP_W-1:0] z;
		logic              status;
	} qfr_res_t;

	logic en, push, pop;

	// Mounting matrix.
	logic [ROW_W-1:0] mount_q [0:NUM_ROWS-1];
	logic signed [COMP_W-1:0] amat [0:2][0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mount_q[0] <= MOUNT_RST0;
			mount_q[1] <= MOUNT_RST1;
			mount_q[2] <= MOUNT_RST2;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROW0: mount_q[0] <= cfg_wdata;
				CFG_ROW1: mount_q[1] <= cfg_wdata;
				CFG_ROW2: mount_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				amat[i][k] = signed'(mount_q[i][COMP_W*k +: COMP_W]);
			end
		end
	end

	// Valid bits of every stage.
	logic v_s1, v_s2, v_m1, v_m2, v_m3, v_m4, v_e1, v_e2, v_e3, v_e4, v_e5, v_q1;
	logic [DIV_LAT-1:0] rdv_q;
	logic [SQ_LAT-1:0]  sqv_q;
	logic [DIV_LAT-1:0] fv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			rdv_q <= '0;
			v_m1  <= 1'b0;
			v_m2  <= 1'b0;
			v_m3  <= 1'b0;
			v_m4  <= 1'b0;
			v_e1  <= 1'b0;
			v_e2  <= 1'b0;
			v_e3  <= 1'b0;
			v_e4  <= 1'b0;
			v_e5  <= 1'b0;
			v_q1  <= 1'b0;
			sqv_q <= '0;
			fv_q  <= '0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			rdv_q <= {rdv_q[DIV_LAT-2:0], v_s2};
			v_m1  <= rdv_q[DIV_LAT-1];
			v_m2  <= v_m1;
			v_m3  <= v_m2;
			v_m4  <= v_m3;
			v_e1  <= v_m4;
			v_e2  <= v_e1;
			v_e3  <= v_e2;
			v_e4  <= v_e3;
			v_e5  <= v_e4;
			v_q1  <= v_e5;
			sqv_q <= {sqv_q[SQ_LAT-2:0], v_q1};
			fv_q  <= {fv_q[DIV_LAT-2:0], sqv_q[SQ_LAT-1]};
		end
	end

	// Squares and cross products of the input.
	logic signed [PR_W-1:0] sq_s1 [0:3];
	logic signed [PR_W-1:0] cr_s1 [0:5];

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1[0] <= PR_W'(in_w) * PR_W'(in_w);
			sq_s1[1] <= PR_W'(in_x) * PR_W'(in_x);
			sq_s1[2] <= PR_W'(in_y) * PR_W'(in_y);
			sq_s1[3] <= PR_W'(in_z) * PR_W'(in_z);
			cr_s1[0] <= PR_W'(in_x) * PR_W'(in_y);
			cr_s1[1] <= PR_W'(in_z) * PR_W'(in_w);
			cr_s1[2] <= PR_W'(in_x) * PR_W'(in_z);
			cr_s1[3] <= PR_W'(in_y) * PR_W'(in_w);
			cr_s1[4] <= PR_W'(in_y) * PR_W'(in_z);
			cr_s1[5] <= PR_W'(in_x) * PR_W'(in_w);
		end
	end

	// Rotation matrix numerators, row major, and the squared length.
	logic signed [NUM_W-1:0] num [0:8];
	logic [DVS_W-1:0]        len2;
	logic [DVS_W-1:0]        nmag_s2 [0:8];
	logic                    nneg_s2 [0:8];
	logic [DVS_W-1:0]        len2_s2;
	logic                    z_s2;

	always_comb begin
		len2 = DVS_W'(sq_s1[0][PR_W-2:0]) + DVS_W'(sq_s1[1][PR_W-2:0])
			+ DVS_W'(sq_s1[2][PR_W-2:0]) + DVS_W'(sq_s1[3][PR_W-2:0]);
		num[0] = NUM_W'(sq_s1[1]) - NUM_W'(sq_s1[2]) - NUM_W'(sq_s1[3]) + NUM_W'(sq_s1[0]);
		num[4] = NUM_W'(sq_s1[2]) - NUM_W'(sq_s1[1]) - NUM_W'(sq_s1[3]) + NUM_W'(sq_s1[0]);
		num[8] = NUM_W'(sq_s1[3]) - NUM_W'(sq_s1[1]) - NUM_W'(sq_s1[2]) + NUM_W'(sq_s1[0]);
		num[3] = (NUM_W'(cr_s1[0]) + NUM_W'(cr_s1[1])) <<< 1;
		num[1] = (NUM_W'(cr_s1[0]) - NUM_W'(cr_s1[1])) <<< 1;
		num[6] = (NUM_W'(cr_s1[2]) - NUM_W'(cr_s1[3])) <<< 1;
		num[2] = (NUM_W'(cr_s1[2]) + NUM_W'(cr_s1[3])) <<< 1;
		num[7] = (NUM_W'(cr_s1[4]) + NUM_W'(cr_s1[5])) <<< 1;
		num[5] = (NUM_W'(cr_s1[4]) - NUM_W'(cr_s1[5])) <<< 1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < 9; e++) begin
				nmag_s2[e] <= num[e][NUM_W-1] ? DVS_W'(-num[e]) : DVS_W'(num[e]);
				nneg_s2[e] <= num[e][NUM_W-1];
			end
			len2_s2 <= len2;
			z_s2    <= len2 == '0;
		end
	end

	// Rotation matrix entries, each rounded to Q2.14.
	logic [DVD_W-1:0]         rdvd [0:8];
	logic signed [COMP_W-1:0] rq   [0:8];
	logic [DIV_LAT-1:0]       rdz_q;

	for (genvar e = 0; e < 9; e++) begin : g_rdiv
		assign rdvd[e] = {nmag_s2[e], {FRAC_W{1'b0}}} + DVD_W'(len2_s2 >> 1);

		qfr_div u_rdiv (
			.clk (clk),
			.en  (en),
			.dvd (rdvd[e]),
			.dvs (len2_s2),
			.neg (nneg_s2[e]),
			.quo (rq[e])
		);
	end

	// Product with the mounting matrix.
	logic signed [PR_W-1:0] mp_m1  [0:8][0:2];
	logic signed [PR_W-1:0] acc_m2 [0:8];
	logic [PM_W-1:0]        pm_m3  [0:8];
	logic                   pneg_m3 [0:8];
	logic signed [P_W-1:0]  p_m4   [0:8];
	logic [PR_W-1:0]        aabs   [0:8];
	logic [PR_W-1:0]        arnd   [0:8];
	logic z_m1, z_m2, z_m3, z_m4;

	always_comb begin
		for (int e = 0; e < 9; e++) begin
			aabs[e] = acc_m2[e][PR_W-1] ? PR_W'(-acc_m2[e]) : PR_W'(acc_m2[e]);
			arnd[e] = aabs[e] + HALF_LSB;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rdz_q <= {rdz_q[DIV_LAT-2:0], z_s2};
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					for (int k = 0; k < 3; k++) begin
						mp_m1[i*3+j][k] <= PR_W'(amat[i][k]) * PR_W'(rq[k*3+j]);
					end
				end
			end
			for (int e = 0; e < 9; e++) begin
				acc_m2[e]  <= mp_m1[e][0] + mp_m1[e][1] + mp_m1[e][2];
				pm_m3[e]   <= arnd[e][FRAC_W +: PM_W];
				pneg_m3[e] <= acc_m2[e][PR_W-1];
				p_m4[e]    <= pneg_m3[e] ? -signed'({1'b0, pm_m3[e]}) : signed'({1'b0, pm_m3[e]});
			end
			z_m1 <= rdz_q[DIV_LAT-1];
			z_m2 <= z_m1;
			z_m3 <= z_m2;
			z_m4 <= z_m3;
		end
	end

	// Quaternion extraction.
	logic signed [C_W-1:0] t_e1, d21_e1, d02_e1, d10_e1, s01_e1, s02_e1, s12_e1;
	logic signed [C_W-1:0] u0_e1, u1_e1, u2_e1;
	logic                  g0_e1, g1_e1, z_e1;
	logic signed [C_W-1:0] c_e2 [0:3];
	logic                  z_e2;
	logic [CM_W-1:0]       cm_e3 [0:3];
	logic [3:0]            cneg_e3;
	logic                  z_e3;

	always_ff @(posedge clk) begin
		if (en) begin
			t_e1   <= C_W'(p_m4[0]) + C_W'(p_m4[4]) + C_W'(p_m4[8]) + ONE_C;
			d21_e1 <= C_W'(p_m4[7]) - C_W'(p_m4[5]);
			d02_e1 <= C_W'(p_m4[2]) - C_W'(p_m4[6]);
			d10_e1 <= C_W'(p_m4[3]) - C_W'(p_m4[1]);
			s01_e1 <= C_W'(p_m4[1]) + C_W'(p_m4[3]);
			s02_e1 <= C_W'(p_m4[2]) + C_W'(p_m4[6]);
			s12_e1 <= C_W'(p_m4[5]) + C_W'(p_m4[7]);
			u0_e1  <= ONE_C + C_W'(p_m4[0]) - C_W'(p_m4[4]) - C_W'(p_m4[8]);
			u1_e1  <= ONE_C + C_W'(p_m4[4]) - C_W'(p_m4[0]) - C_W'(p_m4[8]);
			u2_e1  <= ONE_C + C_W'(p_m4[8]) - C_W'(p_m4[0]) - C_W'(p_m4[4]);
			g0_e1  <= (p_m4[0] > p_m4[4]) && (p_m4[0] > p_m4[8]);
			g1_e1  <= p_m4[4] > p_m4[8];
			z_e1   <= z_m4;

			if (!t_e1[C_W-1] && t_e1 != '0) begin
				c_e2[0] <= t_e1;
				c_e2[1] <= d21_e1;
				c_e2[2] <= d02_e1;
				c_e2[3] <= d10_e1;
			end else if (g0_e1) begin
				c_e2[0] <= d21_e1;
				c_e2[1] <= u0_e1;
				c_e2[2] <= s01_e1;
				c_e2[3] <= s02_e1;
			end else if (g1_e1) begin
				c_e2[0] <= d02_e1;
				c_e2[1] <= s01_e1;
				c_e2[2] <= u1_e1;
				c_e2[3] <= s12_e1;
			end else begin
				c_e2[0] <= d10_e1;
				c_e2[1] <= s02_e1;
				c_e2[2] <= s12_e1;
				c_e2[3] <= u2_e1;
			end
			z_e2 <= z_e1;

			for (int i = 0; i < 4; i++) begin
				cm_e3[i]   <= c_e2[i][C_W-1] ? CM_W'(-c_e2[i]) : CM_W'(c_e2[i]);
				cneg_e3[i] <= c_e2[i][C_W-1];
			end
			z_e3 <= z_e2;
		end
	end

	// Common scaling so that the largest magnitude sits just below bit 30.
	logic [CM_W-1:0]  cor;
	logic [SH_W-1:0]  msb;
	logic [CM_W-1:0]  cm_e4 [0:3];
	logic [3:0]       cneg_e4, cneg_e5, cneg_q1;
	logic [SH_W-1:0]  sh_e4;
	logic             deg_e4, deg_e5, deg_q1, z_e4, z_e5, z_q1;
	logic [MAG_W-1:0] mag_e5 [0:3];
	logic [MAG_W-1:0] mag_q1 [0:3];
	logic [SQM_W-1:0] sqm_q1 [0:3];

	always_comb begin
		cor = cm_e3[0] | cm_e3[1] | cm_e3[2] | cm_e3[3];
		msb = '0;
		for (int b = 0; b < CM_W; b++) begin
			if (cor[b]) begin
				msb = SH_W'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cm_e4   <= cm_e3;
			cneg_e4 <= cneg_e3;
			sh_e4   <= SH_W'(NORM_MSB) - msb;
			deg_e4  <= cor == '0;
			z_e4    <= z_e3;

			for (int i = 0; i < 4; i++) begin
				mag_e5[i] <= MAG_W'(cm_e4[i]) << sh_e4;
			end
			cneg_e5 <= cneg_e4;
			deg_e5  <= deg_e4;
			z_e5    <= z_e4;

			for (int i = 0; i < 4; i++) begin
				sqm_q1[i] <= SQM_W'(mag_e5[i]) * SQM_W'(mag_e5[i]);
			end
			mag_q1  <= mag_e5;
			cneg_q1 <= cneg_e5;
			deg_q1  <= deg_e5;
			z_q1    <= z_e5;
		end
	end

	// Length of the scaled quaternion.
	logic [RAD_W-1:0]  rad;
	qfr_side_t         side_in, side_out;
	logic [ROOT_W-1:0] root;

	always_comb begin
		rad = RAD_W'(sqm_q1[0]) + RAD_W'(sqm_q1[1]) + RAD_W'(sqm_q1[2]) + RAD_W'(sqm_q1[3]);
		for (int i = 0; i < 4; i++) begin
			side_in.mag[i] = mag_q1[i];
		end
		side_in.neg = cneg_q1;
		side_in.deg = deg_q1;
		side_in.err = z_q1;
	end

	qfr_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.rad      (rad),
		.side_in  (side_in),
		.root     (root),
		.side_out (side_out)
	);

	// Scaling to unit length.
	logic [DVD_W-1:0]         fdvd [0:3];
	logic [DVS_W-1:0]         fdvs;
	logic signed [COMP_W-1:0] fq   [0:3];
	logic [DIV_LAT-1:0]       fe_q, fd_q;

	assign fdvs = {1'b0, root, 1'b0};

	for (genvar i = 0; i < 4; i++) begin : g_fdiv
		assign fdvd[i] = DVD_W'({side_out.mag[i], {QB{1'b0}}}) + DVD_W'(root);

		qfr_div u_fdiv (
			.clk (clk),
			.en  (en),
			.dvd (fdvd[i]),
			.dvs (fdvs),
			.neg (side_out.neg[i]),
			.quo (fq[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fe_q <= {fe_q[DIV_LAT-2:0], side_out.err};
			fd_q <= {fd_q[DIV_LAT-2:0], side_out.deg};
		end
	end

	qfr_res_t res;
	logic     blank;

	always_comb begin
		blank      = fe_q[DIV_LAT-1] || fd_q[DIV_LAT-1];
		res.w      = blank ? '0 : fq[0];
		res.x      = blank ? '0 : fq[1];
		res.y      = blank ? '0 : fq[2];
		res.z      = blank ? '0 : fq[3];
		res.status = fe_q[DIV_LAT-1];
	end

	// Output queue.
	qfr_res_t   ent_q [0:FIFO_DEPTH-1];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign en        = cnt_q != 2'(FIFO_DEPTH);
	assign in_ready  = en;
	assign push      = en && fv_q[DIV_LAT-1];
	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= res;
		end
	end

	assign out_w  = signed'(ent_q[rp_q].w);
	assign out_x  = signed'(ent_q[rp_q].x);
	assign out_y  = signed'(ent_q[rp_q].y);
	assign out_z  = signed'(ent_q[rp_q].z);
	assign status = ent_q[rp_q].status;

	`QFR_ASSERT_NOW(a_err_zero, out_valid && status,
		out_w == '0 && out_x == '0 && out_y == '0 && out_z == '0,
		"zero-length item produced nonzero components")
	`QFR_ASSERT_NOW(a_unit_range, out_valid && !status,
		out_w <= 16'sd16384 && out_w >= -16'sd16384 && out_z <= 16'sd16384 && out_z >= -16'sd16384,
		"normalized component exceeds one")
	`QFR_ASSERT_NEXT(a_stall_hold, !en,
		$stable(fv_q) && $stable(sqv_q) && $stable(rdv_q),
		"pipeline valid bits moved during a stall")

endmodule
